// File: design/sca_pkg.sv
// shared types, constants and helpers for the sine / cosine approximation unit
// internal arithmetic is unsigned magnitude or signed q.28; no dependencies
package sca_pkg;

   // q.28 working format: 34 bits signed covers a reduced angle with margin
   localparam int WORK_WIDTH = 34;
   localparam int FRAC_BITS  = 28;

   // q.28 constants
   localparam logic signed [WORK_WIDTH-1:0] K_PI      = 34'sd843314857;
   localparam logic signed [WORK_WIDTH-1:0] K_TWO_PI  = 34'sd1686629713;
   localparam logic signed [WORK_WIDTH-1:0] K_HALF_PI = 34'sd421657428;
   localparam logic signed [WORK_WIDTH-1:0] K_ONE     = 34'sd268435456;
   localparam logic [28:0]                  K_SCALE   = 29'd272139865;

   // constant divisors, their rounding offsets and floor(2^32 / d) reciprocals
   localparam logic [6:0]  DIV_SIN3  = 7'd6;
   localparam logic [6:0]  DIV_COS4  = 7'd24;
   localparam logic [6:0]  DIV_SIN5  = 7'd120;
   localparam logic [5:0]  HALF_SIN3 = 6'd3;
   localparam logic [5:0]  HALF_COS4 = 6'd12;
   localparam logic [5:0]  HALF_SIN5 = 6'd60;
   localparam logic [29:0] RECIP_SIN3 = 30'd715827882;
   localparam logic [29:0] RECIP_COS4 = 30'd178956970;
   localparam logic [29:0] RECIP_SIN5 = 30'd35791394;

   // folded angle, split into magnitude and sign
   typedef struct packed {
      logic        cosine;
      logic        negate;
      logic        sign;
      logic [28:0] mag;
   } range_out_type;

   // powers of the scaled angle, all as q.28 magnitudes
   typedef struct packed {
      logic        cosine;
      logic        negate;
      logic        sign;
      logic [28:0] m;
      logic [29:0] x2;
      logic [30:0] p3;
      logic [31:0] x5;
   } poly_out_type;

   // q.28 product back to q.28, round to nearest, ties away from zero
   function automatic logic [63:0] rnd_q28(input logic [63:0] prod);
      logic [63:0] sum;
      sum = prod + 64'd134217728;
      return sum >> FRAC_BITS;
   endfunction

endpackage

// File: design/sca_range.sv
// range reduction into [-pi, pi] and fold into [-pi/2, pi/2], two stages
// depends on sca_pkg
module sca_range #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_cosine,
   input  logic signed [ANGLE_WIDTH-1:0] in_angle,
   output logic                          out_valid,
   input  logic                          out_ready,
   output sca_pkg::range_out_type        out_data
);
   import sca_pkg::*;

   localparam int SHIFT = 32 - ANGLE_WIDTH;

   logic                          valid1_ff, valid2_ff;
   logic                          adv1, adv2;
   logic signed [WORK_WIDTH-1:0]  angle_q28;
   logic signed [WORK_WIDTH-1:0]  reduced_in, reduced_ff;
   logic                          cosine_in, cosine_ff;
   logic signed [WORK_WIDTH-1:0]  fold_sum;
   range_out_type                 fold_in, fold_ff;

   // stage advance, back to front
   assign adv2     = !valid2_ff || out_ready;
   assign adv1     = !valid1_ff || adv2;
   assign in_ready = adv1;

   // widen to q.28 and bring into [-pi, pi] with one add or subtract of 2pi
   always_comb begin
      angle_q28 = WORK_WIDTH'(in_angle) <<< SHIFT;
      cosine_in = in_cosine;
      if (angle_q28 > K_PI) begin
         reduced_in = angle_q28 - K_TWO_PI;
      end else if (angle_q28 < -K_PI) begin
         reduced_in = angle_q28 + K_TWO_PI;
      end else begin
         reduced_in = angle_q28;
      end
   end

   // fold beyond +/- pi/2 toward zero; a cosine fold flips the result sign
   always_comb begin
      fold_in.cosine = cosine_ff;
      fold_in.negate = 1'b0;
      if (reduced_ff < -K_HALF_PI) begin
         fold_sum       = K_PI + reduced_ff;
         fold_in.sign   = 1'b1;
         fold_in.negate = cosine_ff;
      end else if (reduced_ff > K_HALF_PI) begin
         fold_sum       = K_PI - reduced_ff;
         fold_in.sign   = 1'b0;
         fold_in.negate = cosine_ff;
      end else begin
         fold_sum     = reduced_ff[WORK_WIDTH-1] ? -reduced_ff : reduced_ff;
         fold_in.sign = reduced_ff[WORK_WIDTH-1];
      end
      fold_in.mag = fold_sum[28:0];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (adv1) valid1_ff <= in_valid;
         if (adv2) valid2_ff <= valid1_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv1) begin
         reduced_ff <= reduced_in;
         cosine_ff  <= cosine_in;
      end
      if (adv2) fold_ff <= fold_in;
   end

   assign out_valid = valid2_ff;
   assign out_data  = fold_ff;

endmodule

// File: design/sca_poly.sv
// power chain of the scaled angle: x, x^2, x^3 or x^4, x^5; four stages
// one rounded multiplier per stage; depends on sca_pkg
module sca_poly (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sca_pkg::range_out_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sca_pkg::poly_out_type  out_data
);
   import sca_pkg::*;

   localparam int STAGES = 4;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] adv;
   poly_out_type      s_in [STAGES];
   poly_out_type      s_ff [STAGES];
   logic [57:0]       prod_scale;
   logic [57:0]       prod_sq;
   logic [59:0]       prod_p3;
   logic [60:0]       prod_x5;

   // stage advance, back to front
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end
   assign in_ready = adv[0];

   // one multiply per stage
   assign prod_scale = 58'(in_data.mag) * 58'(K_SCALE);
   assign prod_sq    = 58'(s_ff[0].m) * 58'(s_ff[0].m);
   assign prod_p3    = 60'(s_ff[1].x2) * 60'(s_ff[1].cosine ? s_ff[1].x2 : 30'(s_ff[1].m));
   assign prod_x5    = 61'(s_ff[2].p3) * 61'(s_ff[2].x2);

   always_comb begin
      // scaled angle magnitude
      s_in[0]        = '0;
      s_in[0].cosine = in_data.cosine;
      s_in[0].negate = in_data.negate;
      s_in[0].sign   = in_data.sign;
      s_in[0].m      = 29'(rnd_q28(64'(prod_scale)));
      // square
      s_in[1]        = s_ff[0];
      s_in[1].x2     = 30'(rnd_q28(64'(prod_sq)));
      // fourth power for cosine, cube for sine
      s_in[2]        = s_ff[1];
      s_in[2].p3     = 31'(rnd_q28(64'(prod_p3)));
      // fifth power, used by sine only
      s_in[3]        = s_ff[2];
      s_in[3].x5     = 32'(rnd_q28(64'(prod_x5)));
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (adv[i]) s_ff[i] <= s_in[i];
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = s_ff[STAGES-1];

endmodule

// File: design/sca_series.sv
// series terms by constant division, sum, sign, rounding and saturation
// four stages; divisions use a reciprocal multiply and one correction; depends on sca_pkg
module sca_series #(
   parameter int RESULT_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  sca_pkg::poly_out_type   in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [RESULT_WIDTH-1:0] out_value
);
   import sca_pkg::*;

   localparam int STAGES   = 4;
   localparam int SH       = FRAC_BITS - (RESULT_WIDTH - 2);
   localparam int RM_WIDTH = WORK_WIDTH + 2;
   localparam logic [RM_WIDTH-1:0] MAX_MAG = RM_WIDTH'(1) << (RESULT_WIDTH - 1);

   typedef struct packed {
      logic                  cosine;
      logic                  flip;
      logic [28:0]           m;
      logic [29:0]           x2;
      logic [31:0]           n1;
      logic [29:0]           q1;
      logic [32:0]           n2;
      logic [29:0]           q2;
      logic [WORK_WIDTH-1:0] ymag;
      logic                  yneg;
   } term_type;

   logic [STAGES-1:0]            valid_ff;
   logic [STAGES-1:0]            adv;
   term_type                     s_in [STAGES-1];
   term_type                     s_ff [STAGES-1];
   logic [RESULT_WIDTH-1:0]      value_in, value_ff;
   logic [61:0]                  prod1;
   logic [62:0]                  prod2;
   logic [6:0]                   div1;
   logic [33:0]                  rem1, rem2;
   logic signed [WORK_WIDTH-1:0] total;
   logic [RM_WIDTH-1:0]          rounded_mag;

   // stage advance, back to front
   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end
   assign in_ready = adv[0];

   // reciprocal multiplies: first term divides by 6 or 24, second by 120
   always_comb begin
      s_in[0]        = '0;
      s_in[0].cosine = in_data.cosine;
      s_in[0].flip   = in_data.cosine ? in_data.negate : in_data.sign;
      s_in[0].m      = in_data.m;
      s_in[0].x2     = in_data.x2;
      s_in[0].n1     = 32'(in_data.p3) + 32'(in_data.cosine ? HALF_COS4 : HALF_SIN3);
      s_in[0].n2     = 33'(in_data.x5) + 33'(HALF_SIN5);
      prod1          = 62'(s_in[0].n1) * 62'(in_data.cosine ? RECIP_COS4 : RECIP_SIN3);
      prod2          = 63'(s_in[0].n2) * 63'(RECIP_SIN5);
      s_in[0].q1     = 30'(prod1 >> 32);
      s_in[0].q2     = 30'(prod2 >> 32);
   end

   // quotient correction, halve x^2
   always_comb begin
      s_in[1]    = s_ff[0];
      div1       = s_ff[0].cosine ? DIV_COS4 : DIV_SIN3;
      rem1       = 34'(s_ff[0].n1) - 34'(s_ff[0].q1) * 34'(div1);
      rem2       = 34'(s_ff[0].n2) - 34'(s_ff[0].q2) * 34'(DIV_SIN5);
      s_in[1].q1 = s_ff[0].q1 + 30'(rem1 >= 34'(div1));
      s_in[1].q2 = s_ff[0].q2 + 30'(rem2 >= 34'(DIV_SIN5));
      s_in[1].x2 = 30'((31'(s_ff[0].x2) + 31'd1) >> 1);
   end

   // sum of terms, split into magnitude and final sign
   always_comb begin
      s_in[2] = s_ff[1];
      if (s_ff[1].cosine) begin
         total = K_ONE - WORK_WIDTH'(s_ff[1].x2) + WORK_WIDTH'(s_ff[1].q1);
      end else begin
         total = WORK_WIDTH'(s_ff[1].m) - WORK_WIDTH'(s_ff[1].q1) + WORK_WIDTH'(s_ff[1].q2);
      end
      s_in[2].ymag = total[WORK_WIDTH-1] ? WORK_WIDTH'(-total) : WORK_WIDTH'(total);
      s_in[2].yneg = s_ff[1].flip ^ total[WORK_WIDTH-1];
   end

   // scale the magnitude to the output fraction width
   generate
      if (SH > 0) begin : g_round
         assign rounded_mag = (RM_WIDTH'(s_ff[2].ymag) + (RM_WIDTH'(1) << (SH - 1))) >> SH;
      end else if (SH == 0) begin : g_exact
         assign rounded_mag = RM_WIDTH'(s_ff[2].ymag);
      end else begin : g_widen
         assign rounded_mag = RM_WIDTH'(s_ff[2].ymag) << (-SH);
      end
   endgenerate

   // saturate and apply the sign
   always_comb begin
      if (s_ff[2].yneg) begin
         if (rounded_mag >= MAX_MAG) begin
            value_in = RESULT_WIDTH'(MAX_MAG);
         end else begin
            value_in = RESULT_WIDTH'(RM_WIDTH'(0) - rounded_mag);
         end
      end else begin
         if (rounded_mag >= MAX_MAG) begin
            value_in = RESULT_WIDTH'(MAX_MAG - RM_WIDTH'(1));
         end else begin
            value_in = RESULT_WIDTH'(rounded_mag);
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES - 1; i++) begin
         if (adv[i]) s_ff[i] <= s_in[i];
      end
      if (adv[STAGES-1]) value_ff <= value_in;
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_value = value_ff;

endmodule

// File: design/sine_cosine_approximation_unit.sv
// top level of the sine / cosine approximation unit
// depends on sca_pkg, sca_range, sca_poly and sca_series
//
// Usage:
//   req channel: one beat per angle. tdata carries the angle in radians as
//   signed fixed point with ANGLE_WIDTH-4 fraction bits; tuser selects the
//   function (0 sine, 1 cosine).
//   rsp channel: one beat per request, in request order. tdata carries the
//   result as signed fixed point with RESULT_WIDTH-2 fraction bits, saturated.
//   The angle is wrapped into [-pi, pi], folded into [-pi/2, pi/2], scaled
//   and fed to a three-term Taylor series.
// Timing:
//   ten register stages; a result beat waits in the last stage and is taken
//   at a clock edge while rsp_tready is high. With rsp_tready high throughout,
//   one beat per cycle is sustained; each stage holds multiply, add or compare steps.
// Reset and stall:
//   synchronous reset empties the pipeline; no result is pending afterwards.
//   When rsp_tready is low, each stage holds its item and bubbles close up,
//   so req_tready drops only once every stage is full.
module sine_cosine_approximation_unit #(
   parameter int ANGLE_WIDTH  = 16,
   parameter int RESULT_WIDTH = 16,
   localparam int REQ_DATA_WIDTH = ((ANGLE_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_WIDTH = ((RESULT_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // angle
   input  logic                      req_tuser,   // operation
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata    // value
);
   import sca_pkg::*;

   logic                    range_valid, range_ready;
   range_out_type           range_data;
   logic                    poly_valid, poly_ready;
   poly_out_type            poly_data;
   logic [RESULT_WIDTH-1:0] value;

   // wrap and fold
   sca_range #(
      .ANGLE_WIDTH(ANGLE_WIDTH)
   ) u_range (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cosine (req_tuser),
      .in_angle  (req_tdata[ANGLE_WIDTH-1:0]),
      .out_valid (range_valid),
      .out_ready (range_ready),
      .out_data  (range_data)
   );

   // powers of the scaled angle
   sca_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (range_valid),
      .in_ready  (range_ready),
      .in_data   (range_data),
      .out_valid (poly_valid),
      .out_ready (poly_ready),
      .out_data  (poly_data)
   );

   // series terms, sum and output format
   sca_series #(
      .RESULT_WIDTH(RESULT_WIDTH)
   ) u_series (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (poly_valid),
      .in_ready  (poly_ready),
      .in_data   (poly_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (value)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'(value);

endmodule

// File: design/sca_checker.sv
// port-level checks for the sine / cosine approximation unit, bound to the top level
// depends on sine_cosine_approximation_unit
module sca_checker #(
   parameter int RESULT_WIDTH = 16,
   localparam int RSP_DATA_WIDTH = ((RESULT_WIDTH + 7) / 8) * 8
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // the series never exceeds 1.25 in magnitude
   localparam logic signed [RESULT_WIDTH-1:0] BOUND =
      RESULT_WIDTH'(5 * (2 ** (RESULT_WIDTH - 4)));

   logic signed [RESULT_WIDTH-1:0] value;
   assign value = rsp_tdata[RESULT_WIDTH-1:0];

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat pending after reset");

   // a draining output must never block the request side
   assert property (@(posedge clock) rsp_tready |-> req_tready)
      else $error("request side stalled while output drains");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed or dropped");

   // results stay near the unit circle, never at the clamps
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (value <= BOUND) && (value >= -BOUND))
      else $error("result outside the expected range");

endmodule

bind sine_cosine_approximation_unit sca_checker #(
   .RESULT_WIDTH(RESULT_WIDTH)
) u_sca_checker (.*);

// File: test/sine_cosine_approximation_unit_test.sv
// self-checking testbench for the sine / cosine approximation unit
// depends on design/sine_cosine_approximation_unit.sv and the modules below it
module sine_cosine_approximation_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_BITS   = 16;
   localparam int VALUE_BITS   = 16;
   localparam int RANDOM_BEATS = 1800;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 120;
   localparam int PAUSE_AT     = 1000;
   localparam int QUIET_FIRST  = 1300;
   localparam int QUIET_LAST   = 1500;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic OP_SINE   = 1'b0;
   localparam logic OP_COSINE = 1'b1;

   // expected values of sine / cosine, computed in q.28 like the block
   class sincos_scoreboard;
      localparam longint PI_Q28      = 843314857;
      localparam longint TWO_PI_Q28  = 1686629713;
      localparam longint HALF_PI_Q28 = 421657428;
      localparam longint SCALE_Q28   = 272139865;
      localparam longint ONE_Q28     = 268435456;

      logic [VALUE_BITS-1:0] pending_values[$];
      int mismatches;

      function new();
         mismatches = 0;
      endfunction

      function longint unsigned magnitude(longint v);
         return v < 0 ? longint'(-v) : v;
      endfunction

      // q.28 product, round to nearest, ties away from zero
      function longint round_mul(longint a, longint b);
         longint unsigned p;
         p = magnitude(a) * magnitude(b);
         p = (p + 64'd134217728) >> 28;
         return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
      endfunction

      // division by a small constant, round to nearest, ties away from zero
      function longint round_div(longint a, longint unsigned d);
         longint unsigned r;
         r = (magnitude(a) + d / 2) / d;
         return (a < 0) ? -longint'(r) : longint'(r);
      endfunction

      function logic [VALUE_BITS-1:0] sincos_value(logic cosine, logic [ANGLE_BITS-1:0] angle);
         longint x, x2, x3, x4, x5, y;
         longint unsigned m;
         logic negate;
         negate = 1'b0;
         // widen q3.12 to q.28
         x = longint'($signed(angle)) * 65536;
         // wrap into [-pi, pi]
         while (x > PI_Q28) x -= TWO_PI_Q28;
         while (x < -PI_Q28) x += TWO_PI_Q28;
         // fold into [-pi/2, pi/2]; cosine changes sign across the fold
         if (x < -HALF_PI_Q28) begin
            x = -PI_Q28 - x;
            negate = cosine;
         end else if (x > HALF_PI_Q28) begin
            x = PI_Q28 - x;
            negate = cosine;
         end
         x = round_mul(x, SCALE_Q28);
         x2 = round_mul(x, x);
         // three-term taylor series
         if (cosine) begin
            x4 = round_mul(x2, x2);
            y = ONE_Q28 - round_div(x2, 2) + round_div(x4, 24);
         end else begin
            x3 = round_mul(x2, x);
            x5 = round_mul(x3, x2);
            y = x - round_div(x3, 6) + round_div(x5, 120);
         end
         if (negate) y = -y;
         // q.28 to q1.14 with rounding, then saturate
         m = (magnitude(y) + 64'd8192) >> 14;
         y = (y < 0) ? -longint'(m) : longint'(m);
         if (y > 32767) y = 32767;
         if (y < -32768) y = -32768;
         return y[VALUE_BITS-1:0];
      endfunction

      function void note_angle(logic operation, logic [ANGLE_BITS-1:0] angle);
         pending_values.push_back(sincos_value(operation, angle));
      endfunction

      function void check_value(logic [VALUE_BITS-1:0] actual);
         logic [VALUE_BITS-1:0] wanted;
         if (pending_values.size() == 0) begin
            $error("value: expected none, actual %0d", $signed(actual));
            mismatches++;
            return;
         end
         wanted = pending_values.pop_front();
         if (actual !== wanted) begin
            $error("value: expected %0d, actual %0d", $signed(wanted), $signed(actual));
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ANGLE_BITS-1:0] req_tdata = '0;   // angle
   logic                  req_tuser = 1'b0; // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [VALUE_BITS-1:0] rsp_tdata;        // value
   int                    cycle_count = 0;
   sincos_scoreboard      board;

   sine_cosine_approximation_unit #(
      .ANGLE_WIDTH(ANGLE_BITS),
      .RESULT_WIDTH(VALUE_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // offer one request beat after an idle gap, note it once accepted
   task automatic send_beat(logic operation, logic [ANGLE_BITS-1:0] angle, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      req_tuser  <= operation;
      do @(posedge clock); while (!req_tready);
      board.note_angle(operation, angle);
   endtask

   // mostly uniform angles, some close to the wrap and fold points
   function automatic logic [ANGLE_BITS-1:0] pick_angle();
      int edges[3] = '{6434, 12868, 25736};
      int a;
      if ($urandom_range(0, 3) != 0) return ANGLE_BITS'($urandom_range(0, 65535));
      a = edges[$urandom_range(0, 2)] + $urandom_range(0, 16) - 8;
      if ($urandom_range(0, 1) != 0) a = -a;
      return ANGLE_BITS'(a);
   endfunction

   task automatic run_sender();
      logic [ANGLE_BITS-1:0] corners[12] = '{
         16'sd0, -16'sd1, 16'sd4096, 16'sd6434, -16'sd6434, 16'sd12867,
         16'sd12868, -16'sd12868, 16'sd25736, -16'sd25736, 16'sd32767, -16'sd32768
      };
      int gap;
      // directed: corners of the angle range, both operations
      foreach (corners[i]) begin
         send_beat(OP_SINE, corners[i], $urandom_range(0, 4));
         send_beat(OP_COSINE, corners[i], $urandom_range(0, 4));
      end
      // random beats
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == PAUSE_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (board.pending_values.size() != 0);
         end
         gap = (n >= QUIET_FIRST && n < QUIET_LAST) ? 0 : $urandom_range(0, 4);
         send_beat(logic'($urandom_range(0, 1)), pick_angle(), gap);
      end
      req_tvalid <= 1'b0;
   endtask

   // response side: random stalls, one long hold-off, one stall-free stretch
   task automatic run_receiver();
      int served;
      int stall;
      served = 0;
      forever begin
         if (served == HOLD_AT) stall = HOLD_CYCLES;
         else if (served >= QUIET_FIRST && served < QUIET_LAST + 50) stall = 0;
         else stall = $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_value(rsp_tdata);
         served++;
      end
   endtask

   initial begin
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         run_receiver();
      join_none
      run_sender();
      while (board.pending_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending_values.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
